>>> rtl/tbac_pkg.sv
package tbac_pkg;

    // Register index codes and widths
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_THR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTEND_THR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRACT_MS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_PULSE_MIN  = 16'd1000;
    localparam logic [15:0] RST_PULSE_MAX  = 16'd2000;
    localparam logic [7:0]  RST_DRIVE_MAX  = 8'd255;
    localparam logic [15:0] RST_AUTO_THR   = 16'd1400;
    localparam logic [15:0] RST_EXTEND_THR = 16'd2000;
    localparam logic [15:0] RST_RETRACT_MS = 16'd2000;
    localparam logic [11:0] RST_DEADBAND   = 12'd50;

    // Autonomous mapping: speed/10 by reciprocal, then scale by drive_max/150
    localparam logic [15:0] RECIP_TEN       = 16'd52429;
    localparam int          RECIP_TEN_SHIFT = 19;
    localparam logic [15:0] AUTO_SPAN       = 16'd150;

    // Shared divider geometry
    localparam int DIV_W = 24;
    localparam int DEN_W = 16;
    localparam int CNT_W = $clog2(DIV_W);

    // Actuator command codes
    localparam logic [1:0] CMD_STOP    = 2'd0;
    localparam logic [1:0] CMD_EXTEND  = 2'd1;
    localparam logic [1:0] CMD_RETRACT = 2'd2;

    typedef struct packed {
        logic        kind;
        logic        pin_level;
        logic [31:0] time_us;
        logic [31:0] time_ms;
        logic [15:0] mode_pulse_us;
        logic        danger;
        logic        warning;
        logic [11:0] speed_mms;
        logic        limit_switch;
    } in_item_t;

    typedef struct packed {
        logic [7:0] drive_code;
        logic [1:0] actuator_cmd;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_stat_t;

endpackage

>>> rtl/tbac_stream_if.sv
interface tbac_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/tbac_divider.sv
module tbac_divider
    import tbac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,
    output div_stat_t stat
);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
            cnt_next  = CNT_W'(DIV_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
            end
            quo_next = {quo_reg[DIV_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

>>> rtl/tbac_actuator.sv
module tbac_actuator
    import tbac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [31:0] pulse_width,
    input  logic        limit_switch,
    input  logic [31:0] time_ms,
    input  logic [15:0] extend_thr,
    input  logic [15:0] retract_ms,
    output logic [1:0]  cmd
);

    logic        extended_reg, extended_next;
    logic        retracting_reg, retracting_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] elapsed;

    assign elapsed = time_ms - start_reg;

    // Decide the command and the next flag state for one control item
    always_comb
    begin
        cmd             = CMD_STOP;
        extended_next   = extended_reg;
        retracting_next = retracting_reg;
        start_next      = start_reg;
        if (pulse_width > {16'b0, extend_thr})
        begin
            if (limit_switch)
            begin
                cmd             = CMD_EXTEND;
                extended_next   = 1'b1;
                retracting_next = 1'b0;
            end
        end
        else if (extended_reg && !retracting_reg)
        begin
            cmd             = CMD_RETRACT;
            start_next      = time_ms;
            retracting_next = 1'b1;
        end
        else if (retracting_reg)
        begin
            if (elapsed >= {16'b0, retract_ms})
            begin
                retracting_next = 1'b0;
                extended_next   = 1'b0;
            end
            else
            begin
                cmd = CMD_RETRACT;
            end
        end
    end

    // Advance only when a control item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extended_reg   <= 1'b0;
            retracting_reg <= 1'b0;
            start_reg      <= '0;
        end
        else if (step)
        begin
            extended_reg   <= extended_next;
            retracting_reg <= retracting_next;
            start_reg      <= start_next;
        end
    end

endmodule

>>> rtl/throttle_and_brake_actuator_control.sv
// Throttle DAC drive and brake actuator controller.
//
// Items come in on in_ch (valid/ready). An edge item (kind 0) updates the
// stored rise time or pulse width and gives no result, and edge items can
// follow back to back. A control item (kind 1) gives exactly one result on
// out_ch: the DAC drive code and the actuator command.
// When the drive code needs the serial divider (24 quotient bits, one per
// cycle, plus set-up and scaling steps) the item passes through the PREP,
// MUL, DIV, FIN and OUT states; when danger, the deadband, the pulse window
// or an empty span settles the code, it goes from PREP straight to FIN and
// OUT. in_ch.ready is high only while the sequencer is idle, so one item is
// in work at a time.
// The result waits in an output register; while the receiver stalls, the
// block still takes the next item and finishes it, then holds until the
// register is free.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, the block itself does not enforce this. Unknown
// indexes are ignored. Reset restores the default register values and clears
// all timing and actuator state; no clearing pass is needed.
module throttle_and_brake_actuator_control
    import tbac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    tbac_stream_if.sink          in_ch,
    tbac_stream_if.source        out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [15:0] pulse_min_reg, pulse_max_reg, auto_thr_reg;
    logic [15:0] extend_thr_reg, retract_ms_reg;
    logic [7:0]  drive_max_reg;
    logic [11:0] deadband_reg;

    // Edge timing state
    logic [31:0] edge_start_reg, pulse_width_reg;

    // Per-item work registers
    logic        danger_reg, warning_reg, auto_reg;
    logic [11:0] speed_reg;
    logic [1:0]  cmd_reg;
    logic [15:0] a_reg, a_next;
    logic [15:0] den_reg, den_next;
    logic [7:0]  base_reg, base_next;
    logic [7:0]  drive_reg, drive_next;

    // Output register
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    logic        in_acc, ctrl_acc, out_load;
    logic [1:0]  act_cmd;
    logic [27:0] speed_prod;
    logic        in_win;
    logic [15:0] span;
    logic [9:0]  warn_sum;
    div_req_t    div_req;
    div_stat_t   div_stat;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign ctrl_acc    = in_acc && in_ch.data.kind;
    assign out_load    = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_min_reg  <= RST_PULSE_MIN;
            pulse_max_reg  <= RST_PULSE_MAX;
            drive_max_reg  <= RST_DRIVE_MAX;
            auto_thr_reg   <= RST_AUTO_THR;
            extend_thr_reg <= RST_EXTEND_THR;
            retract_ms_reg <= RST_RETRACT_MS;
            deadband_reg   <= RST_DEADBAND;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PULSE_MIN:  pulse_min_reg  <= cfg_data;
                CFG_PULSE_MAX:  pulse_max_reg  <= cfg_data;
                CFG_DRIVE_MAX:  drive_max_reg  <= cfg_data[7:0];
                CFG_AUTO_THR:   auto_thr_reg   <= cfg_data;
                CFG_EXTEND_THR: extend_thr_reg <= cfg_data;
                CFG_RETRACT_MS: retract_ms_reg <= cfg_data;
                CFG_DEADBAND:   deadband_reg   <= cfg_data[11:0];
                default:        ;
            endcase
        end
    end

    // Record rise time, store pulse width on a falling edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_start_reg  <= '0;
            pulse_width_reg <= '0;
        end
        else if (in_acc && !in_ch.data.kind)
        begin
            if (in_ch.data.pin_level)
            begin
                edge_start_reg <= in_ch.data.time_us;
            end
            else
            begin
                pulse_width_reg <= in_ch.data.time_us - edge_start_reg;
            end
        end
    end

    tbac_actuator u_actuator (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (ctrl_acc),
        .pulse_width  (pulse_width_reg),
        .limit_switch (in_ch.data.limit_switch),
        .time_ms      (in_ch.data.time_ms),
        .extend_thr   (extend_thr_reg),
        .retract_ms   (retract_ms_reg),
        .cmd          (act_cmd)
    );

    // Capture the control item
    always_ff @(posedge clk)
    begin
        if (ctrl_acc)
        begin
            danger_reg  <= in_ch.data.danger;
            warning_reg <= in_ch.data.warning;
            auto_reg    <= in_ch.data.mode_pulse_us > auto_thr_reg;
            speed_reg   <= in_ch.data.speed_mms;
            cmd_reg     <= act_cmd;
        end
    end

    assign speed_prod = {16'b0, speed_reg} * {12'b0, RECIP_TEN};
    assign in_win     = (pulse_width_reg >= {16'b0, pulse_min_reg})
                        && (pulse_width_reg <= {16'b0, pulse_max_reg});
    assign span       = pulse_max_reg - pulse_min_reg;
    assign warn_sum   = {2'b0, base_reg} + {1'b0, base_reg, 1'b0};

    always_comb
    begin
        div_req.start    = (state_reg == ST_MUL);
        div_req.dividend = {8'b0, a_reg} * {16'b0, drive_max_reg};
        div_req.divisor  = den_reg;
    end

    tbac_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        den_next   = den_reg;
        base_next  = base_reg;
        drive_next = drive_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl_acc)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_FIN;
                base_next  = '0;
                if (danger_reg)
                begin
                    base_next = '0;
                end
                else if (auto_reg)
                begin
                    if (speed_reg > deadband_reg)
                    begin
                        a_next     = {7'b0, speed_prod[RECIP_TEN_SHIFT +: 9]};
                        den_next   = AUTO_SPAN;
                        state_next = ST_MUL;
                    end
                end
                else if (in_win)
                begin
                    if (span == '0)
                    begin
                        base_next = drive_max_reg;
                    end
                    else
                    begin
                        a_next     = pulse_width_reg[15:0] - pulse_min_reg;
                        den_next   = span;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_FIN;
                    if (auto_reg)
                    begin
                        if (div_stat.quotient > {16'b0, drive_max_reg})
                        begin
                            base_next = drive_max_reg;
                        end
                        else
                        begin
                            base_next = div_stat.quotient[7:0];
                        end
                    end
                    else
                    begin
                        base_next = drive_max_reg - div_stat.quotient[7:0];
                    end
                end
            end
            ST_FIN:
            begin
                // Scale by three quarters on a warning; danger already gave zero
                drive_next = (warning_reg && !danger_reg) ? warn_sum[9:2] : base_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        den_reg   <= den_next;
        base_reg  <= base_next;
        drive_reg <= drive_next;
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.drive_code   <= drive_reg;
            out_data_reg.actuator_cmd <= cmd_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // The divider only runs while the sequencer waits on it
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == ST_DIV)
        else $error("divider busy outside the divide step");

    // An edge item never starts a computation
    a_edge_no_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !in_ch.data.kind) |=> state_reg == ST_IDLE)
        else $error("edge item started a computation");

    // The unscaled drive never exceeds full throttle
    a_base_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |-> base_reg <= drive_max_reg)
        else $error("drive above drive_max");

    // A shown result carries a defined actuator command
    a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.data.actuator_cmd == CMD_STOP
                          || out_ch.data.actuator_cmd == CMD_EXTEND
                          || out_ch.data.actuator_cmd == CMD_RETRACT))
        else $error("undefined actuator command");

endmodule

>>> sim/throttle_and_brake_actuator_control_checker.sv
module throttle_and_brake_actuator_control_checker
    import tbac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   pending
);

    // Shadow copy of the configuration registers
    logic [31:0] win_lo;
    logic [31:0] win_hi;
    logic [31:0] full_code;
    logic [31:0] auto_thr;
    logic [31:0] ext_thr;
    logic [31:0] retract_len;
    logic [31:0] dead_band;

    // Shadow copy of the pulse timing and brake state
    logic [31:0] rise_time_us;
    logic [31:0] measured_width_us;
    logic        brake_extended;
    logic        brake_retracting;
    logic [31:0] retract_t0_ms;

    // Drive/command pairs owed by the block, oldest first
    out_item_t   awaited_out[$];

    task automatic log_failure(input string what);
        if (errors < 10)
            $display("%0t: %s", $time, what);
        errors++;
    endtask

    // Work out the drive code and actuator command for one control item
    task automatic compute_drive_and_brake(input in_item_t item, output out_item_t res);
        logic [31:0] width;
        logic [31:0] code;
        logic [31:0] span;
        logic [1:0]  cmd;
        width = measured_width_us;
        code  = '0;
        if (!item.danger) begin
            if (item.mode_pulse_us > auto_thr) begin
                if (item.speed_mms > dead_band) begin
                    code = (32'(item.speed_mms) / 10) * full_code / 150;
                    if (code > full_code)
                        code = full_code;
                end
            end
            else if (width >= win_lo && width <= win_hi) begin
                span = win_hi - win_lo;
                if (span == 0)
                    code = full_code;
                else
                    code = full_code - ((width - win_lo) * full_code) / span;
            end
            if (item.warning)
                code = (code * 3) >> 2;
        end

        // Extend while the width exceeds ext_thr with the limit switch set, retract for a timed period after
        if (width > ext_thr) begin
            if (item.limit_switch) begin
                cmd              = CMD_EXTEND;
                brake_extended   = 1'b1;
                brake_retracting = 1'b0;
            end
            else begin
                cmd = CMD_STOP;
            end
        end
        else if (brake_extended && !brake_retracting) begin
            cmd              = CMD_RETRACT;
            retract_t0_ms    = item.time_ms;
            brake_retracting = 1'b1;
        end
        else if (brake_retracting) begin
            if (32'(item.time_ms - retract_t0_ms) >= retract_len) begin
                cmd              = CMD_STOP;
                brake_retracting = 1'b0;
                brake_extended   = 1'b0;
            end
            else begin
                cmd = CMD_RETRACT;
            end
        end
        else begin
            cmd = CMD_STOP;
        end

        res.drive_code   = code[7:0];
        res.actuator_cmd = cmd;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        out_item_t want;
        out_item_t fresh;
        if (!rst_n) begin
            win_lo            = 32'(RST_PULSE_MIN);
            win_hi            = 32'(RST_PULSE_MAX);
            full_code         = 32'(RST_DRIVE_MAX);
            auto_thr          = 32'(RST_AUTO_THR);
            ext_thr           = 32'(RST_EXTEND_THR);
            retract_len       = 32'(RST_RETRACT_MS);
            dead_band         = 32'(RST_DEADBAND);
            rise_time_us      = '0;
            measured_width_us = '0;
            brake_extended    = 1'b0;
            brake_retracting  = 1'b0;
            retract_t0_ms     = '0;
            awaited_out.delete();
            pending = 0;
        end
        else begin
            // Track register writes; unknown indexes change nothing
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PULSE_MIN:  win_lo      = 32'(cfg_data);
                    CFG_PULSE_MAX:  win_hi      = 32'(cfg_data);
                    CFG_DRIVE_MAX:  full_code   = 32'(cfg_data[7:0]);
                    CFG_AUTO_THR:   auto_thr    = 32'(cfg_data);
                    CFG_EXTEND_THR: ext_thr     = 32'(cfg_data);
                    CFG_RETRACT_MS: retract_len = 32'(cfg_data);
                    CFG_DEADBAND:   dead_band   = 32'(cfg_data[11:0]);
                    default: ;
                endcase
            end

            // Compare each result with the oldest owed one
            if (out_valid && out_ready) begin
                if (awaited_out.size() == 0) begin
                    log_failure($sformatf("unexpected result: drive %0d cmd %0d",
                                          out_data.drive_code, out_data.actuator_cmd));
                end
                else begin
                    want = awaited_out.pop_front();
                    if (out_data.drive_code !== want.drive_code)
                        log_failure($sformatf("drive_code: expected %0d, got %0d",
                                              want.drive_code, out_data.drive_code));
                    if (out_data.actuator_cmd !== want.actuator_cmd)
                        log_failure($sformatf("actuator_cmd: expected %0d, got %0d",
                                              want.actuator_cmd, out_data.actuator_cmd));
                end
            end

            // Advance the shadow state on each accepted item
            if (in_valid && in_ready) begin
                if (in_data.kind) begin
                    compute_drive_and_brake(in_data, fresh);
                    awaited_out.push_back(fresh);
                end
                else if (in_data.pin_level) begin
                    rise_time_us = in_data.time_us;
                end
                else begin
                    measured_width_us = in_data.time_us - rise_time_us;
                end
            end
            pending = awaited_out.size();
        end
    end

endmodule

>>> sim/throttle_and_brake_actuator_control_tb.sv
module throttle_and_brake_actuator_control_tb;
    import tbac_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 140;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int errors;
    int pending;
    int idle_pct;
    int stall_pct;
    int sent;

    // Running pin and control-step clocks for the stimulus
    logic [31:0] us_now;
    logic [31:0] ms_now;

    // Register values currently loaded into the block
    int unsigned pulse_min;
    int unsigned pulse_max;
    int unsigned drive_max;
    int unsigned auto_thr;
    int unsigned extend_thr;
    int unsigned retract_ms;
    int unsigned deadband;

    tbac_stream_if #(.payload_t(in_item_t))  in_ch ();
    tbac_stream_if #(.payload_t(out_item_t)) out_ch ();

    throttle_and_brake_actuator_control u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    throttle_and_brake_actuator_control_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_data   (in_ch.data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result channel at random
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic in_item_t random_fill();
        logic [127:0] noise;
        noise = {$urandom(), $urandom(), $urandom(), $urandom()};
        return noise[$bits(in_item_t)-1:0];
    endfunction

    function automatic in_item_t edge_item(input logic level, input logic [31:0] t_us);
        in_item_t it;
        it           = random_fill();
        it.kind      = 1'b0;
        it.pin_level = level;
        it.time_us   = t_us;
        return it;
    endfunction

    function automatic in_item_t control_with(input logic [15:0] mode,
                                              input logic [11:0] speed,
                                              input logic        danger,
                                              input logic        warning,
                                              input logic        limit,
                                              input logic [31:0] t_ms);
        in_item_t it;
        it               = random_fill();
        it.kind          = 1'b1;
        it.mode_pulse_us = mode;
        it.speed_mms     = speed;
        it.danger        = danger;
        it.warning       = warning;
        it.limit_switch  = limit;
        it.time_ms       = t_ms;
        return it;
    endfunction

    // Random control step, biased toward the mode and deadband edges
    function automatic in_item_t control_item(input logic limit);
        logic [15:0] mode;
        logic [11:0] speed;
        case ($urandom_range(0, 9))
            0:       mode = 16'(auto_thr);
            1:       mode = 16'(auto_thr + 1);
            2, 3, 4: mode = 16'($urandom_range(0, auto_thr));
            default: mode = 16'($urandom_range(0, 65535));
        endcase
        if ($urandom_range(0, 1))
            speed = 12'(deadband + $urandom_range(0, 40) - 20);
        else
            speed = 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 19) == 0)
            ms_now = $urandom();
        else
            ms_now += $urandom_range(0, 20);
        return control_with(mode, speed, ($urandom_range(0, 7) == 0),
                            ($urandom_range(0, 3) == 0), limit, ms_now);
    endfunction

    // Pulse width biased toward the manual window and the extend threshold
    function automatic logic [31:0] pick_width();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(pulse_min, pulse_max);
            5:
            begin
                case ($urandom_range(0, 3))
                    0:       return pulse_min - 1;
                    1:       return pulse_min;
                    2:       return pulse_max;
                    default: return pulse_max + 1;
                endcase
            end
            6, 7:    return extend_thr + $urandom_range(0, 200) - 100;
            8:       return $urandom_range(0, 65535);
            default: return $urandom();
        endcase
    endfunction

    task automatic send(input in_item_t it);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_pulse(input logic [31:0] width);
        send(edge_item(1'b1, us_now));
        send(edge_item(1'b0, us_now + width));
        us_now = us_now + width + $urandom_range(1, 5000);
    endtask

    // Hold off until every owed result has come, then let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_config();
        write_reg(CFG_PULSE_MIN, CFG_W'(pulse_min));
        write_reg(CFG_PULSE_MAX, CFG_W'(pulse_max));
        write_reg(CFG_DRIVE_MAX, CFG_W'(drive_max));
        write_reg(CFG_AUTO_THR, CFG_W'(auto_thr));
        write_reg(CFG_EXTEND_THR, CFG_W'(extend_thr));
        write_reg(CFG_RETRACT_MS, CFG_W'(retract_ms));
        write_reg(CFG_DEADBAND, CFG_W'(deadband));
        write_reg(CFG_NONE, CFG_W'($urandom()));
        cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        pulse_min  = $urandom_range(0, 3000);
        pulse_max  = pulse_min + $urandom_range(1, 3000);
        drive_max  = $urandom_range(0, 255);
        auto_thr   = $urandom_range(0, 3000);
        extend_thr = $urandom_range(1000, 4000);
        retract_ms = $urandom_range(0, 3000);
        deadband   = $urandom_range(0, 1000);
    endtask

    task automatic run_random(input int n_items);
        int first;
        int sel;
        first = sent;
        while (sent - first < n_items)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
            begin
                // measure a pulse and act on it
                send_pulse(pick_width());
                repeat ($urandom_range(1, 3)) send(control_item($urandom_range(0, 9) < 7));
            end
            else if (sel < 65)
            begin
                // full brake cycle: extend, hit the limit, release, timed retract
                send_pulse(extend_thr + $urandom_range(1, 500));
                repeat ($urandom_range(1, 2)) send(control_item(1'b1));
                repeat ($urandom_range(0, 2)) send(control_item(1'b0));
                send_pulse($urandom_range(0, extend_thr));
                repeat ($urandom_range(2, 5))
                begin
                    ms_now += $urandom_range(0, retract_ms / 2 + 10);
                    send(control_item(1'($urandom_range(0, 1))));
                end
            end
            else if (sel < 85)
            begin
                send(control_item(1'($urandom_range(0, 1))));
            end
            else
            begin
                // stray edges: double rises, falls with no rise, wrapped times
                send(edge_item(1'($urandom_range(0, 1)), $urandom()));
            end
        end
    endtask

    initial
    begin
        logic [31:0] t0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        sent        = 0;
        pulse_min   = 32'(RST_PULSE_MIN);
        pulse_max   = 32'(RST_PULSE_MAX);
        drive_max   = 32'(RST_DRIVE_MAX);
        auto_thr    = 32'(RST_AUTO_THR);
        extend_thr  = 32'(RST_EXTEND_THR);
        retract_ms  = 32'(RST_RETRACT_MS);
        deadband    = 32'(RST_DEADBAND);
        us_now      = $urandom();
        ms_now      = $urandom();
        t0          = 32'hFFFF_FC00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks on the reset configuration
        send(edge_item(1'b1, 32'd100));
        send(edge_item(1'b0, 32'd1600));
        send(control_with(16'd0, 12'd0, 1'b0, 1'b0, 1'b1, ms_now));
        send(control_with(16'd0, 12'd0, 1'b0, 1'b1, 1'b1, ms_now));
        send(control_with(16'hFFFF, 12'hFFF, 1'b1, 1'b1, 1'b1, ms_now));
        send(control_with(16'd1401, 12'hFFF, 1'b0, 1'b0, 1'b1, ms_now));
        send(control_with(16'd1401, 12'hFFF, 1'b0, 1'b1, 1'b1, ms_now));
        send(control_with(16'hFFFF, 12'd50, 1'b0, 1'b0, 1'b1, ms_now));
        send(control_with(16'hFFFF, 12'd51, 1'b0, 1'b0, 1'b1, ms_now));
        send(control_with(16'd1400, 12'hFFF, 1'b0, 1'b0, 1'b1, ms_now));
        // pulse measured across the timestamp wrap, at the window floor
        send(edge_item(1'b1, 32'hFFFF_FF00));
        send(edge_item(1'b0, 32'h0000_02E8));
        send(control_with(16'd0, 12'd0, 1'b0, 1'b0, 1'b1, ms_now));
        // falling edge with no new rise, at the window ceiling
        send(edge_item(1'b0, 32'h0000_06D0));
        send(control_with(16'd0, 12'd0, 1'b0, 1'b0, 1'b1, ms_now));
        // extend, stop at the limit, then retract across the ms wrap
        send(edge_item(1'b1, 32'd5000));
        send(edge_item(1'b0, 32'd7500));
        send(control_with(16'd0, 12'd0, 1'b0, 1'b0, 1'b1, ms_now));
        send(control_with(16'd0, 12'd0, 1'b0, 1'b0, 1'b0, ms_now));
        send(edge_item(1'b1, 32'd8000));
        send(edge_item(1'b0, 32'd8999));
        send(control_with(16'd0, 12'd0, 1'b0, 1'b0, 1'b1, t0));
        send(control_with(16'd0, 12'd0, 1'b0, 1'b0, 1'b1, t0 + 32'd1999));
        send(control_with(16'd0, 12'd0, 1'b0, 1'b0, 1'b1, t0 + 32'd2000));
        send(control_with(16'd0, 12'd0, 1'b0, 1'b0, 1'b1, t0 + 32'd2001));
        drain();

        // Random phases, each under its own configuration and idling pattern
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                1:
                begin
                    pulse_min  = 0;
                    pulse_max  = 65535;
                    drive_max  = 255;
                    auto_thr   = 0;
                    extend_thr = 65535;
                    retract_ms = 0;
                    deadband   = 0;
                end
                2:
                begin
                    // empty manual window, slowest retraction
                    pulse_min  = 40000;
                    pulse_max  = 100;
                    drive_max  = 0;
                    auto_thr   = 65535;
                    extend_thr = 0;
                    retract_ms = 65535;
                    deadband   = 4095;
                end
                3:
                begin
                    // window collapsed to a single width
                    random_config();
                    pulse_min = $urandom_range(500, 2500);
                    pulse_max = pulse_min;
                    drive_max = 255;
                end
                6:
                begin
                    pulse_min  = 32'(RST_PULSE_MIN);
                    pulse_max  = 32'(RST_PULSE_MAX);
                    drive_max  = 32'(RST_DRIVE_MAX);
                    auto_thr   = 32'(RST_AUTO_THR);
                    extend_thr = 32'(RST_EXTEND_THR);
                    retract_ms = 32'(RST_RETRACT_MS);
                    deadband   = 32'(RST_DEADBAND);
                end
                default: random_config();
            endcase
            case (ph % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 75;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 75;
                end
                default:
                begin
                    idle_pct  = 7;
                    stall_pct = 7;
                end
            endcase
            load_config();
            run_random(PHASE_ITEMS);
            drain();
        end

        if (pending != 0)
            $display("%0d results never arrived", pending);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
